// ===== design/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// States, control bundle and constant tables shared by the hasher modules.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int LEN_FIELD_BITS = 64;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_REQ,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         count_byte;
      logic         len_load;
      logic         len_shift;
      logic         load_work;
      logic         round_en;
      logic         final_add;
      logic         init_chain;
      logic [5:0]   round_idx;
   } ctrl_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INITIAL_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;

endpackage

// ===== design/shs_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Block window, working variables and chaining words; one round per cycle.
// ----------------------------------------------------------------------------
module shs_core
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic [7:0]  byte_in,
   input  logic [2:0]  out_sel,
   output logic [31:0] out_word
);

   logic [31:0] win_ff   [16];
   logic [31:0] win_in   [16];
   logic [31:0] work_ff  [8];
   logic [31:0] work_in  [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];

   logic [31:0] big1, big0, choose, major, t1, t2, sig0, sig1, new_w;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      big1   = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + big1 + choose + ROUND_K[ctrl.round_idx] + win_ff[0];
      big0   = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
      t2     = big0 + major;
      sig0   = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      sig1   = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      new_w  = sig1 + win_ff[9] + sig0 + win_ff[0];
   end

   // bytes shift in big-endian; rounds shift the schedule window by a word
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         win_in[j] = win_ff[j];
      end
      if (ctrl.shift_en) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = {win_ff[j][23:0], win_ff[j+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], byte_in};
      end else if (ctrl.round_en) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = win_ff[j+1];
         end
         win_in[15] = new_w;
      end
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         work_in[j] = work_ff[j];
      end
      if (ctrl.load_work) begin
         for (int j = 0; j < 8; j++) begin
            work_in[j] = chain_ff[j];
         end
      end else if (ctrl.round_en) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         chain_in[j] = chain_ff[j];
      end
      if (ctrl.init_chain) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = INITIAL_H[j];
         end
      end else if (ctrl.final_add) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = chain_ff[j] + work_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 16; j++) begin
         win_ff[j] <= win_in[j];
      end
      for (int j = 0; j < 8; j++) begin
         work_ff[j] <= work_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= INITIAL_H[j];
         end
      end else begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= chain_in[j];
         end
      end
   end

   assign out_word = chain_ff[out_sel];

endmodule

// ===== design/shs_sequencer.sv =====
// ----------------------------------------------------------------------------
// SHA-256 sequencer
// Absorb, padding, length, rounds and digest output control.
// ----------------------------------------------------------------------------
module shs_sequencer
   import shs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   input  logic       rsp_ready,
   output logic       req_ready,
   output logic       rsp_valid,
   output logic [2:0] rsp_index,
   output logic       rsp_last,
   output ctrl_type   ctrl
);

   state_type  state_ff, state_in, ret_ff, ret_in;
   logic [5:0] fill_ff, fill_in, fill_next;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic       first_ff, first_in;
   logic       req_fire, rsp_fire;

   assign req_fire  = req_valid && (state_ff == ST_IDLE);
   assign rsp_fire  = rsp_ready && (state_ff == ST_OUT);
   assign fill_next = fill_ff + 6'd1;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      first_in = first_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_FINISH) begin
                  state_in = ST_PAD;
                  first_in = 1'b1;
               end else begin
                  fill_in = fill_next;
                  if (fill_next == 6'd0) begin
                     state_in = ST_ROUND;
                     ret_in   = ST_IDLE;
                  end
               end
            end
         end
         ST_PAD: begin
            fill_in  = fill_next;
            first_in = 1'b0;
            priority if (fill_next == 6'd0) begin
               state_in = ST_ROUND;
               ret_in   = ST_PAD;
            end else if (fill_next == LEN_START) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            fill_in = fill_next;
            if (fill_next == 6'd0) begin
               state_in = ST_ROUND;
               ret_in   = ST_OUT;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.byte_sel  = SEL_REQ;
      ctrl.round_idx = round_ff;
      ctrl.load_work = (state_in == ST_ROUND) && (state_ff != ST_ROUND);
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctrl.shift_en   = req_fire && (req_mode == MODE_ABSORB);
            ctrl.count_byte = req_fire && (req_mode == MODE_ABSORB);
         end
         ST_PAD: begin
            ctrl.shift_en = 1'b1;
            ctrl.byte_sel = first_ff ? SEL_PAD : SEL_ZERO;
            ctrl.len_load = (fill_next == LEN_START);
         end
         ST_LEN: begin
            ctrl.shift_en  = 1'b1;
            ctrl.byte_sel  = SEL_LEN;
            ctrl.len_shift = 1'b1;
         end
         ST_ROUND: begin
            ctrl.round_en = 1'b1;
         end
         ST_FINAL: begin
            ctrl.final_add = 1'b1;
         end
         ST_OUT: begin
            rsp_valid       = 1'b1;
            ctrl.init_chain = rsp_fire && (idx_ff == LAST_WORD_IDX);
         end
         default: begin
            ctrl.shift_en = 1'b0;
         end
      endcase
   end

   assign rsp_index = idx_ff;
   assign rsp_last  = (idx_ff == LAST_WORD_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// Absorb: a data word is taken from idle; the 64th byte of a block also starts the
// 64 rounds in the shared round unit plus one chaining add.
// Finish: padding and length bytes (9 to 72) shift in one per cycle, paused by a
// compression where they spill into a second block, then a final compression and 8
// digest words at one per cycle when taken; no new byte is taken during rounds.
// Reset (synchronous): idle, chaining words at the initial hash values, counts zero.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs one message byte per word and streams out the eight digest words.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
   import shs_pkg::*;
#(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   ctrl_type                  ctrl;
   logic [LENGTH_WIDTH-1:0]   bits_ff, bits_in;
   logic [LEN_FIELD_BITS-1:0] len_ff, len_in;
   logic [7:0]                byte_mux;
   logic [2:0]                word_idx;
   logic [31:0]               digest;

   shs_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .rsp_ready (rsp_tready),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_index (word_idx),
      .rsp_last  (rsp_tlast),
      .ctrl      (ctrl)
   );

   always_comb begin
      unique case (ctrl.byte_sel)
         SEL_REQ:  byte_mux = req_tdata;
         SEL_PAD:  byte_mux = PAD_BYTE;
         SEL_ZERO: byte_mux = 8'h00;
         SEL_LEN:  byte_mux = len_ff[LEN_FIELD_BITS-1 -: 8];
         default:  byte_mux = 8'h00;
      endcase
   end

   shs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .byte_in  (byte_mux),
      .out_sel  (word_idx),
      .out_word (digest)
   );

   // message length in bits, wraps at LENGTH_WIDTH
   always_comb begin
      bits_in = bits_ff;
      if (ctrl.init_chain) begin
         bits_in = '0;
      end else if (ctrl.count_byte) begin
         bits_in = bits_ff + LENGTH_WIDTH'(8);
      end
   end

   always_comb begin
      len_in = len_ff;
      if (ctrl.len_load) begin
         len_in = LEN_FIELD_BITS'(bits_ff);
      end else if (ctrl.len_shift) begin
         len_in = {len_ff[LEN_FIELD_BITS-9:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   assign rsp_tdata = {5'b00000, word_idx, digest};

`ifndef SYNTHESIS
   a_one_side_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest is being sent");

   a_finish_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !req_tready)
      else $error("ready right after a finish word");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after the last digest word");
`endif

endmodule

// ===== sim/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte messages and finish words through the request stream and checks
// every digest word against a local SHA-256 model or a stored known digest. A
// short table of messages around the padding boundaries runs first, then random
// messages, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher
   import shs_pkg::*;
();

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_word_type;

   // one table row: a message of n_bytes, then a finish word
   typedef struct packed {
      logic [7:0]   n_bytes;
      logic [7:0]   first;
      logic         step;      // 0: constant byte, 1: incrementing bytes
      logic         known;
      logic [255:0] digest;
   } dir_msg_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_MOSTLY,
      RX_SPARSE,
      RX_PERIODIC
   } rx_pattern_type;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam int N_DIR = 10;
   localparam dir_msg_type DIR_PLAN [N_DIR] = '{
      '{8'd0,  8'h00, 1'b0, 1'b1, EMPTY_DIGEST},
      '{8'd3,  8'h61, 1'b1, 1'b1, ABC_DIGEST},
      '{8'd1,  8'h00, 1'b0, 1'b0, 256'h0},
      '{8'd1,  8'hff, 1'b0, 1'b0, 256'h0},
      '{8'd55, 8'ha5, 1'b0, 1'b0, 256'h0},   // padding just fits one block
      '{8'd56, 8'h00, 1'b1, 1'b0, 256'h0},   // length spills to a second block
      '{8'd63, 8'hff, 1'b0, 1'b0, 256'h0},
      '{8'd64, 8'h80, 1'b1, 1'b0, 256'h0},   // exact block, padding block alone
      '{8'd65, 8'h5a, 1'b1, 1'b0, 256'h0},
      '{8'd0,  8'h00, 1'b0, 1'b1, EMPTY_DIGEST}
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int RANDOM_ITEMS = 140;
   localparam int LONG_HOLD    = 600;
   localparam int HOLD_AT_WORD = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   // model state
   logic [31:0] chain_h [8];
   logic [7:0]  blk [64];
   logic [5:0]  fill;
   logic [63:0] msg_bits;

   digest_word_type digest_q [$];
   int errors;
   int burst_left;

   sha256_byte_stream_hasher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[sha256_byte_stream_hasher] ERROR");
      $finish;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_reset();
      chain_h  = SHA_H0;
      fill     = '0;
      msg_bits = '0;
   endfunction

   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + SHA_K[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   function automatic void sha_absorb(input logic [7:0] data);
      blk[fill] = data;
      fill      = fill + 6'd1;
      msg_bits  = msg_bits + 64'd8;
      if (fill == 6'd0)
         sha_compress();
   endfunction

   function automatic logic [255:0] sha_finish();
      int i;
      logic [255:0] dg;
      i = fill;
      blk[i] = 8'h80;
      i++;
      if (i > 56) begin
         while (i < 64) begin
            blk[i] = 8'h00;
            i++;
         end
         sha_compress();
         i = 0;
      end
      while (i < 56) begin
         blk[i] = 8'h00;
         i++;
      end
      for (int k = 0; k < 8; k++)
         blk[63-k] = msg_bits[8*k +: 8];
      sha_compress();
      for (int k = 0; k < 8; k++)
         dg[255-32*k -: 32] = chain_h[k];
      sha_reset();
      return dg;
   endfunction

   // Offer one word; on acceptance update the model, then maybe idle a while.
   task automatic offer_word(input logic mode, input logic [7:0] data,
                             input logic use_known, input logic [255:0] known);
      logic [255:0] dg;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == MODE_FINISH) begin
         dg = sha_finish();
         if (use_known)
            dg = known;
         for (int k = 0; k < 8; k++)
            digest_q.push_back('{dg[255-32*k -: 32], 3'(k), k == 7});
      end else begin
         sha_absorb(data);
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom_range(0, 255));
            req_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_digest_drain();
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   // output side: stall patterns plus one long hold-off
   initial begin : rsp_side
      digest_word_type exp_w;
      rx_pattern_type  rx_pat;
      int pat_left;
      int hold_left;
      int words_seen;
      logic hold_done;
      int cyc;
      rsp_tready = 1'b0;
      rx_pat     = RX_OPEN;
      pat_left   = 0;
      hold_left  = 0;
      words_seen = 0;
      hold_done  = 1'b0;
      cyc        = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected digest word, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               exp_w = digest_q.pop_front();
               if (rsp_tdata[31:0] !== exp_w.word) begin
                  errors++;
                  $display("%0t: digest word %0d expected %h got %h",
                           $time, exp_w.idx, exp_w.word, rsp_tdata[31:0]);
               end
               if (rsp_tdata[34:32] !== exp_w.idx) begin
                  errors++;
                  $display("%0t: word index expected %0d got %0d",
                           $time, exp_w.idx, rsp_tdata[34:32]);
               end
               if (rsp_tlast !== exp_w.last) begin
                  errors++;
                  $display("%0t: last flag expected %b got %b",
                           $time, exp_w.last, rsp_tlast);
               end
               if (rsp_tdata[39:35] !== 5'd0) begin
                  errors++;
                  $display("%0t: fill bits expected 0 got %h", $time, rsp_tdata[39:35]);
               end
            end
            words_seen++;
         end
         if (!hold_done && words_seen >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (pat_left == 0) begin
            pat_left = $urandom_range(20, 80);
            rx_pat   = rx_pattern_type'($urandom_range(0, 3));
         end else begin
            pat_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_pat)
               RX_OPEN:     rsp_tready <= 1'b1;
               RX_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= cyc[2];
            endcase
         end
      end
   end

   initial begin : req_side
      dir_msg_type row;
      int n_items;
      int len;
      int sel;
      logic paused;
      errors     = 0;
      burst_left = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = MODE_ABSORB;
      sha_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_DIR; r++) begin
         row = DIR_PLAN[r];
         for (int j = 0; j < row.n_bytes; j++)
            offer_word(MODE_ABSORB, row.step ? row.first + 8'(j) : row.first, 1'b0, '0);
         offer_word(MODE_FINISH, 8'($urandom_range(0, 255)), row.known, row.digest);
      end
      req_tvalid <= 1'b0;
      wait_digest_drain();

      n_items = 0;
      paused  = 1'b0;
      while (n_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6)
            len = $urandom_range(0, 20);
         else if (sel < 9)
            len = $urandom_range(50, 70);    // around the padding boundaries
         else
            len = $urandom_range(100, 140);
         for (int j = 0; j < len; j++)
            offer_word(MODE_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
         offer_word(MODE_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
         n_items += len + 1;
         if (!paused && n_items > RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            wait_digest_drain();
         end
      end
      req_tvalid <= 1'b0;

      wait_digest_drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("[sha256_byte_stream_hasher] OK");
      else
         $display("[sha256_byte_stream_hasher] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/shs_pkg.sv
design/shs_core.sv
design/shs_sequencer.sv
design/sha256_byte_stream_hasher.sv
sim/tb_sha256_byte_stream_hasher.sv
